@@ design/htw_pkg.sv @@
`timescale 1ns / 1ps
package htw_pkg;
    localparam int WHEEL_SLOTS = 256;
    localparam int SLOT_DEPTH  = 8;
    localparam int SLOT_W  = $clog2(WHEEL_SLOTS);
    localparam int POS_W   = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int FILL_W  = $clog2(SLOT_DEPTH + 1);
    localparam int ROUND_W = (16 - SLOT_W > 0) ? 16 - SLOT_W : 1;
    localparam int ADDR_W  = SLOT_W + POS_W;
    localparam int DEPTH   = WHEEL_SLOTS * SLOT_DEPTH;

    localparam logic [1:0] KIND_INSERT  = 2'd0;
    localparam logic [1:0] KIND_TICK    = 2'd1;
    localparam logic [1:0] KIND_CANCEL  = 2'd2;
    localparam logic [1:0] KIND_IGNORED = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_CANCELLED = 3'd2;
    localparam logic [2:0] ST_NOTFOUND  = 3'd3;
    localparam logic [2:0] ST_TICK      = 3'd4;

    // Command handed from the front end to the wheel engine
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] handle;
        logic [15:0] due;
    } htw_cmd_t;

    // Stored entry
    typedef struct packed {
        logic [15:0]        handle;
        logic [15:0]        due;
        logic [ROUND_W-1:0] rounds;
    } htw_entry_t;

    // One result beat
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] handle;
        logic        hvalid;
        logic        last;
    } htw_res_t;
endpackage

@@ design/htw_front.sv @@
`timescale 1ns / 1ps
module htw_front import htw_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  htw_cmd_t in_cmd,
    output logic     q_valid,
    input  logic     q_ready,
    output htw_cmd_t q_cmd
);
    // Two-entry queue; unknown kinds are dropped at the door
    htw_cmd_t  mem_reg [2];
    logic      wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign push = in_valid && in_ready && (in_cmd.kind != KIND_IGNORED);
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_cmd = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_cmd;
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

@@ design/htw_engine.sv @@
`timescale 1ns / 1ps
module htw_engine import htw_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     q_valid,
    output logic     q_ready,
    input  htw_cmd_t q_cmd,
    output logic     r_valid,
    input  logic     r_ready,
    output htw_res_t r_data
);
    localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_EVAL = 3'd2,
                           S_OUT = 3'd3, S_CLR = 3'd4;

    // Entry store and per-slot fill counts
    htw_entry_t  ram [DEPTH];
    logic [FILL_W-1:0] fill [WHEEL_SLOTS];
    htw_entry_t  rdata_reg;
    logic [FILL_W-1:0] fill_rd_reg;

    logic [2:0]  state_reg;
    htw_cmd_t    cmd_reg;
    logic [SLOT_W-1:0] slot_reg, cur_reg, clr_reg;
    logic [FILL_W-1:0] ri_reg, wi_reg, n_reg;
    logic        emitted_reg, found_reg, fin_reg, swap_reg;
    logic [15:0] pend_reg, nxt_reg;
    htw_res_t    res_reg;
    logic        rv_reg;

    logic [ADDR_W-1:0] raddr, waddr;
    logic we, fwe;
    htw_entry_t wdata;
    logic [FILL_W-1:0] fwdata;
    logic [SLOT_W-1:0] qslot;
    logic res_load;

    assign q_ready = (state_reg == S_IDLE) && !rv_reg;
    assign r_valid = rv_reg;
    assign r_data  = res_reg;
    assign qslot = (q_cmd.kind == KIND_TICK) ? cur_reg : q_cmd.due[SLOT_W-1:0];
    assign raddr = {slot_reg, ri_reg[POS_W-1:0]};

    // Read port, registered
    always_ff @(posedge aclk) begin
        rdata_reg <= ram[raddr];
        fill_rd_reg <= fill[(state_reg == S_IDLE) ? qslot : slot_reg];
        if (we) ram[waddr] <= wdata;
        if (fwe) fill[(state_reg == S_CLR) ? clr_reg : slot_reg] <= fwdata;
    end

    // Compaction: reads walk ri, surviving entries are written at wi
    logic last_rd;
    assign last_rd = (ri_reg + 1'b1 >= n_reg);

    always_comb begin
        we = 1'b0; fwe = 1'b0;
        waddr = {slot_reg, wi_reg[POS_W-1:0]};
        wdata = rdata_reg;
        fwdata = '0;
        if (state_reg == S_CLR) begin
            fwe = 1'b1;
        end else if (state_reg == S_RD && cmd_reg.kind == KIND_INSERT
                     && fill_rd_reg < FILL_W'(SLOT_DEPTH)) begin
            we = 1'b1;
            waddr = {slot_reg, fill_rd_reg[POS_W-1:0]};
            wdata.handle = cmd_reg.handle;
            wdata.due = cmd_reg.due;
            wdata.rounds = ROUND_W'(cmd_reg.due >> SLOT_W);
            fwe = 1'b1;
            fwdata = fill_rd_reg + 1'b1;
        end else if (state_reg == S_EVAL) begin
            if (cmd_reg.kind == KIND_TICK) begin
                we = (rdata_reg.rounds != '0);
                wdata.rounds = rdata_reg.rounds - 1'b1;
                fwe = last_rd;
                fwdata = wi_reg + FILL_W'(we);
            end else begin
                we = found_reg || (rdata_reg.due != cmd_reg.due);
                fwe = last_rd && (found_reg || rdata_reg.due == cmd_reg.due);
                fwdata = n_reg - 1'b1;
            end
        end
    end

    // A new result beat is loaded into the output register
    assign res_load = (state_reg == S_RD
                       && (cmd_reg.kind == KIND_INSERT || fill_rd_reg == '0))
                   || (state_reg == S_EVAL && cmd_reg.kind != KIND_TICK && last_rd)
                   || (state_reg == S_OUT && (!rv_reg || r_ready));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR; clr_reg <= '0; cur_reg <= '0; rv_reg <= 1'b0;
        end else begin
            if (res_load) rv_reg <= 1'b1;
            else if (r_ready) rv_reg <= 1'b0;
            unique case (state_reg)
                S_CLR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == SLOT_W'(WHEEL_SLOTS - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: if (q_valid && q_ready) begin
                    cmd_reg <= q_cmd; slot_reg <= qslot;
                    ri_reg <= '0; wi_reg <= '0;
                    emitted_reg <= 1'b0; found_reg <= 1'b0; swap_reg <= 1'b0;
                    state_reg <= S_RD;
                end
                S_RD: begin
                    n_reg <= fill_rd_reg;
                    if (cmd_reg.kind == KIND_INSERT) begin
                        res_reg <= '{(fill_rd_reg < FILL_W'(SLOT_DEPTH)) ?
                                     ST_INSERTED : ST_FULL, 16'd0, 1'b0, 1'b1};
                        state_reg <= S_IDLE;
                    end else if (fill_rd_reg == '0) begin
                        res_reg <= (cmd_reg.kind == KIND_TICK) ?
                            '{ST_TICK, 16'd0, 1'b0, 1'b1} :
                            '{ST_NOTFOUND, 16'd0, 1'b0, 1'b1};
                        if (cmd_reg.kind == KIND_TICK) cur_reg <= cur_reg + 1'b1;
                        state_reg <= S_IDLE;
                    end else begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    ri_reg <= ri_reg + 1'b1;
                    if (we) wi_reg <= wi_reg + 1'b1;
                    if (cmd_reg.kind == KIND_CANCEL
                        && rdata_reg.due == cmd_reg.due) found_reg <= 1'b1;
                    fin_reg <= last_rd;
                    if (cmd_reg.kind == KIND_TICK) begin
                        if (!we && emitted_reg) begin
                            // Next expiry found: the buffered one goes out with last clear
                            nxt_reg <= rdata_reg.handle;
                            swap_reg <= 1'b1;
                            state_reg <= S_OUT;
                        end else begin
                            if (!we) begin
                                pend_reg <= rdata_reg.handle;
                                emitted_reg <= 1'b1;
                            end
                            state_reg <= last_rd ? S_OUT : S_RD;
                        end
                    end else if (last_rd) begin
                        res_reg <= '{(found_reg || rdata_reg.due == cmd_reg.due) ?
                                     ST_CANCELLED : ST_NOTFOUND, 16'd0, 1'b0, 1'b1};
                        state_reg <= S_IDLE;
                    end else state_reg <= S_RD;
                end
                S_OUT: begin
                    // Buffered expiry goes out once the next one, or the end, is known
                    if (!rv_reg || r_ready) begin
                        if (swap_reg) begin
                            res_reg <= '{ST_TICK, pend_reg, 1'b1, 1'b0};
                            pend_reg <= nxt_reg;
                            swap_reg <= 1'b0;
                            if (!fin_reg) state_reg <= S_RD;
                        end else begin
                            cur_reg <= cur_reg + 1'b1;
                            res_reg <= emitted_reg ? '{ST_TICK, pend_reg, 1'b1, 1'b1} :
                                                     '{ST_TICK, 16'd0, 1'b0, 1'b1};
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

@@ design/hashed_timing_wheel.sv @@
`timescale 1ns / 1ps
// Hashed timing wheel with 256 slots of up to 8 entries each.
// Input channel s_axis: one beat per command (insert, tick, cancel);
// kind 3 is dropped without a result.
// Output channel m_axis: one beat per result; tlast marks the final beat
// of a command. A tick gives one beat per expired handle, or one empty beat.
// A two-deep command queue sits in front of the wheel engine, so the input
// keeps taking beats, until both entries are full, while the engine works or the output stalls.
// An insert writes its entry in S_RD; a cancel or tick walks the stored
// entries of its slot, alternating S_RD and S_EVAL, and a tick sends each
// expired entry out through S_OUT. The engine reads and rewrites one entry
// at a time through the entry memory's separate read and write ports.
// The engine takes a new command only when idle and its last result beat
// has been taken.
// Reset: synchronous, active low; the fill counts are then cleared one slot
// per cycle, and no command is started until all of them are cleared.
// A stalled receiver holds the engine; results are never dropped.
module hashed_timing_wheel import htw_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // task_handle[15:0], due_tick[31:16]
    input  logic [1:0]  s_axis_tuser,  // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // status[2:0], expired_handle[18:3], pad
    output logic        m_axis_tuser,  // handle_valid
    output logic        m_axis_tlast
);
    htw_cmd_t in_cmd, q_cmd;
    htw_res_t res;
    logic q_valid, q_ready;

    assign in_cmd = '{s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16]};

    htw_front u_front (.aclk, .aresetn, .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready), .in_cmd, .q_valid, .q_ready, .q_cmd);

    htw_engine u_engine (.aclk, .aresetn, .q_valid, .q_ready, .q_cmd,
        .r_valid(m_axis_tvalid), .r_ready(m_axis_tready), .r_data(res));

    assign m_axis_tdata = {5'd0, res.handle, res.status};
    assign m_axis_tuser = res.hvalid;
    assign m_axis_tlast = res.last;
endmodule

@@ design/htw_checker.sv @@
`timescale 1ns / 1ps
module htw_checker import htw_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);
    // Output beat holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    // Valid handle only on tick results
    a_hv: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[2:0] == ST_TICK)
        else $error("handle on non-tick result");
    // Non-tick results are single beats
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[2:0] != ST_TICK |-> m_axis_tlast)
        else $error("multi-beat non-tick result");
    // A beat without handle has a zero handle field and is the final beat
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[18:3] == 16'd0 && m_axis_tlast)
        else $error("bad empty result");
endmodule

bind hashed_timing_wheel htw_checker u_htw_checker (.*);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import htw_pkg::*;

    localparam int MAX_EXPIRE = 8;

    typedef struct {
        logic [2:0]  status;
        logic [15:0] handle;
        logic        hvalid;
        logic        last;
    } wheel_result_t;

    typedef struct {
        logic [15:0] handle;
        logic [15:0] due;
        int          rounds;
    } wheel_slot_entry_t;

    // Directed row: command plus optional hand-typed expected status
    typedef struct {
        logic [1:0]  kind;
        logic [15:0] handle;
        logic [15:0] due;
        bit          has_exp;
        logic [2:0]  exp_status;
    } directed_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    hashed_timing_wheel u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Shadow wheel
    wheel_slot_entry_t wheel_slots[WHEEL_SLOTS][$];
    int                wheel_ptr;
    wheel_result_t     pending_results[$];
    int                error_count;
    bit                rx_hold;

    // Expected status per directed row, checked on the final beat
    logic [2:0]        typed_status[$];
    bit                typed_valid[$];

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic wheel_result_t mk_result(logic [2:0] st, logic [15:0] h,
                                                logic hv, logic lst);
        wheel_result_t r;
        r.status = st;
        r.handle = h;
        r.hvalid = hv;
        r.last   = lst;
        return r;
    endfunction

    // Apply one command to the shadow wheel and queue its results
    task automatic predict_wheel(input logic [1:0] kind, input logic [15:0] handle,
                                 input logic [15:0] due);
        int                slot;
        int                i;
        int                fired;
        bit                found;
        wheel_slot_entry_t e;
        slot = due % WHEEL_SLOTS;
        case (kind)
            KIND_INSERT: begin
                if (wheel_slots[slot].size() >= SLOT_DEPTH) begin
                    pending_results.push_back(mk_result(ST_FULL, '0, 1'b0, 1'b1));
                end else begin
                    e.handle = handle;
                    e.due    = due;
                    e.rounds = due / WHEEL_SLOTS;
                    wheel_slots[slot].push_back(e);
                    pending_results.push_back(mk_result(ST_INSERTED, '0, 1'b0, 1'b1));
                end
            end
            KIND_CANCEL: begin
                found = 1'b0;
                for (i = 0; i < wheel_slots[slot].size(); i++) begin
                    if (!found && wheel_slots[slot][i].due == due) begin
                        wheel_slots[slot].delete(i);
                        found = 1'b1;
                        break;
                    end
                end
                pending_results.push_back(mk_result(found ? ST_CANCELLED : ST_NOTFOUND,
                                                    '0, 1'b0, 1'b1));
            end
            KIND_TICK: begin
                fired = 0;
                i = 0;
                while (i < wheel_slots[wheel_ptr].size()) begin
                    if (wheel_slots[wheel_ptr][i].rounds == 0) begin
                        if (fired < MAX_EXPIRE) begin
                            pending_results.push_back(mk_result(ST_TICK,
                                wheel_slots[wheel_ptr][i].handle, 1'b1, 1'b0));
                            wheel_slots[wheel_ptr].delete(i);
                            fired++;
                        end else begin
                            i++;
                        end
                    end else begin
                        wheel_slots[wheel_ptr][i].rounds--;
                        i++;
                    end
                end
                if (fired == 0)
                    pending_results.push_back(mk_result(ST_TICK, '0, 1'b0, 1'b1));
                else
                    pending_results[$].last = 1'b1;
                wheel_ptr = (wheel_ptr + 1) % WHEEL_SLOTS;
            end
            default: ;
        endcase
    endtask

    // Send one beat; the predictor runs on acceptance. Valid stays up for a
    // back-to-back beat and drops only over a gap.
    task automatic send_beat(input logic [1:0] kind, input logic [15:0] handle,
                             input logic [15:0] due, input bit has_exp,
                             input logic [2:0] exp_status);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {due, handle};
        s_axis_tuser  <= kind;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        if (kind != KIND_IGNORED) begin
            typed_valid.push_back(has_exp);
            typed_status.push_back(exp_status);
        end
        predict_wheel(kind, handle, due);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Receiver side: random stalls, with one long hold-off on request
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (rx_hold) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                rx_hold = 1'b0;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        wheel_result_t exp_r;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                exp_r = pending_results.pop_front();
                if (m_axis_tdata[2:0] !== exp_r.status)
                    report_mismatch($sformatf("status %0d want %0d",
                                              m_axis_tdata[2:0], exp_r.status));
                if (m_axis_tdata[18:3] !== exp_r.handle)
                    report_mismatch($sformatf("handle %h want %h",
                                              m_axis_tdata[18:3], exp_r.handle));
                if (m_axis_tuser !== exp_r.hvalid)
                    report_mismatch("handle_valid differs");
                if (m_axis_tlast !== exp_r.last)
                    report_mismatch("tlast differs");
                if (m_axis_tdata[23:19] !== 5'd0)
                    report_mismatch("pad bits not zero");
                if (exp_r.last && typed_valid.size() != 0) begin
                    if (typed_valid.pop_front() && m_axis_tdata[2:0] !== typed_status[0])
                        report_mismatch("directed status differs");
                    void'(typed_status.pop_front());
                end
            end
        end
    end

    initial begin
        #100ms;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        directed_row_t rows[$];
        logic [1:0]    kind;
        logic [15:0]   due;
        int            n;
        int            hot;
        int            r;

        error_count   = 0;
        wheel_ptr     = 0;
        rx_hold       = 1'b0;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_INSERT;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty tick, extremes, full slot, cancel hit/miss, ignored kind
        rows.push_back('{KIND_TICK,   16'h0000, 16'h0000, 1'b1, ST_TICK});
        rows.push_back('{KIND_CANCEL, 16'h0000, 16'h0005, 1'b1, ST_NOTFOUND});
        rows.push_back('{KIND_INSERT, 16'hffff, 16'hffff, 1'b1, ST_INSERTED});
        rows.push_back('{KIND_INSERT, 16'h0000, 16'h0001, 1'b1, ST_INSERTED});
        for (int k = 0; k < SLOT_DEPTH; k++)
            rows.push_back('{KIND_INSERT, 16'h1000 + 16'(k), 16'h0002 + 16'(k << 8),
                             1'b1, ST_INSERTED});
        rows.push_back('{KIND_INSERT, 16'hbeef, 16'h0002, 1'b1, ST_FULL});
        rows.push_back('{KIND_IGNORED, 16'haaaa, 16'h5555, 1'b0, ST_INSERTED});
        rows.push_back('{KIND_CANCEL, 16'h0000, 16'h0302, 1'b1, ST_CANCELLED});
        rows.push_back('{KIND_CANCEL, 16'h0000, 16'hffff, 1'b1, ST_CANCELLED});
        rows.push_back('{KIND_TICK,   16'h0000, 16'h0000, 1'b0, ST_TICK});
        rows.push_back('{KIND_TICK,   16'h0000, 16'h0000, 1'b0, ST_TICK});
        rows.push_back('{KIND_TICK,   16'h0000, 16'h0000, 1'b0, ST_TICK});
        foreach (rows[i])
            send_beat(rows[i].kind, rows[i].handle, rows[i].due,
                      rows[i].has_exp, rows[i].exp_status);

        // Sender pauses until all results are in
        wait_drained();

        // Receiver holds off while the sender keeps pushing
        rx_hold = 1'b1;
        for (int k = 0; k < 12; k++)
            send_beat(KIND_INSERT, 16'($urandom), 16'($urandom), 1'b0, ST_INSERTED);

        // Random: inserts, mostly near-term on slots close to the pointer, plus ticks, cancels and ignored kinds
        for (n = 0; n < 400; n++) begin
            hot = $urandom_range(0, 9);
            r = $urandom_range(0, 99);
            if (r < 45) begin
                kind = KIND_INSERT;
                if (r < 35)
                    due = 16'(((wheel_ptr + hot) % WHEEL_SLOTS)
                              + WHEEL_SLOTS * $urandom_range(0, 2));
                else
                    due = 16'($urandom);
            end else if (r < 80) begin
                kind = KIND_TICK;
                due = 16'($urandom);
            end else if (r < 97) begin
                kind = KIND_CANCEL;
                due = (r < 92 && wheel_slots[(wheel_ptr + hot) % WHEEL_SLOTS].size() != 0)
                    ? wheel_slots[(wheel_ptr + hot) % WHEEL_SLOTS][0].due
                    : 16'($urandom);
            end else begin
                kind = KIND_IGNORED;
                due = 16'($urandom);
            end
            send_beat(kind, 16'($urandom), due, 1'b0, ST_INSERTED);
        end

        wait_drained();
        repeat (50) @(posedge aclk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
